>>> hw/rtl/dars_pkg.sv
// Shared types, codes and constants for the daily alarm reminder scheduler.
`timescale 1ns / 1ps
`default_nettype none

package dars_pkg;

  localparam int SLOTS_DEFAULT = 8;

  localparam logic [15:0] RESET_INTERVAL = 16'd300;
  localparam logic [3:0]  RESET_LIMIT    = 4'd3;
  localparam logic [15:0] RESET_MISSED   = 16'd1800;
  localparam logic [10:0] MINUTE_MAX     = 11'd1439;

  localparam logic [1:0] CFG_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_MISSED   = 2'd2;

  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_APPEND     = 3'd1,
    MODE_SET_TIME   = 3'd2,
    MODE_SET_ENABLE = 3'd3,
    MODE_REMOVE     = 3'd4,
    MODE_CONFIRM    = 3'd5,
    MODE_SNOOZE     = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_FIRST  = 3'd1,
    ACT_REPEAT = 3'd2,
    ACT_MISSED = 3'd3,
    ACT_ACK    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SET_TIME   = 3'd1,
    OP_SET_ENABLE = 3'd2,
    OP_CONFIRM    = 3'd3,
    OP_SNOOZE     = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_RD1,
    S_EV1,
    S_RD2,
    S_EV2,
    S_ERD,
    S_EWR,
    S_MRD,
    S_MWR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [10:0] minute;
    logic        enabled;
    logic        done;
    logic [3:0]  sent;
    logic [31:0] last;
    logic [15:0] day;
    action_t     act;
  } entry_t;

  typedef struct packed {
    logic [15:0] interval;
    logic [3:0]  limit;
    logic [15:0] missed;
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/dars_if.sv
// Valid/ready channel interfaces for scheduler items and results.
`timescale 1ns / 1ps
`default_nettype none

interface dars_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [2:0]  slot;
  logic [10:0] alarm_minute;
  logic        enable_flag;
  logic [15:0] day_number;
  logic [10:0] minute_now;
  logic [31:0] seconds_now;

  modport source (
    output valid, mode, slot, alarm_minute, enable_flag, day_number, minute_now,
           seconds_now,
    input  ready
  );
  modport sink (
    input  valid, mode, slot, alarm_minute, enable_flag, day_number, minute_now,
           seconds_now,
    output ready
  );
endinterface

interface dars_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_slot;
  logic [2:0] action;
  logic [1:0] status;
  logic       any_pending;
  logic       last_of_run;

  modport source (
    output valid, result_slot, action, status, any_pending, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_slot, action, status, any_pending, last_of_run,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/dars_slot_unit.sv
// Shared slot update unit: one entry through tick, edit and snooze rules.
`timescale 1ns / 1ps
`default_nettype none

module dars_slot_unit
  import dars_pkg::*;
(
  input  op_t         op,
  input  entry_t      cur,
  input  cfg_t        cfg,
  input  logic [15:0] day,
  input  logic [10:0] minute,
  input  logic [31:0] now,
  input  logic [10:0] amin,
  input  logic        en,
  output entry_t      nxt
);

  entry_t      tick_e;
  logic [31:0] sub_b;
  logic [31:0] diff;

  always_comb begin
    tick_e = cur;
    if (cur.day != day) begin
      tick_e.done = 1'b0;
      tick_e.sent = 4'd0;
      tick_e.last = 32'd0;
      tick_e.day  = day;
    end
  end

  assign sub_b = (op == OP_SNOOZE) ? {16'd0, cfg.interval} : tick_e.last;
  assign diff  = now - sub_b;

  always_comb begin
    nxt = cur;
    unique case (op)
      OP_TICK: begin
        nxt     = tick_e;
        nxt.act = ACT_NONE;
        if (tick_e.enabled && !tick_e.done && (minute >= cur.minute)) begin
          if (tick_e.sent == 4'd0) begin
            nxt.sent = 4'd1;
            nxt.last = now;
            nxt.act  = ACT_FIRST;
          end else if ((tick_e.sent < cfg.limit) && (diff >= {16'd0, cfg.interval})) begin
            nxt.sent = tick_e.sent + 4'd1;
            nxt.last = now;
            nxt.act  = ACT_REPEAT;
          end else if ((tick_e.sent >= cfg.limit) && (diff >= {16'd0, cfg.missed})) begin
            nxt.done = 1'b1;
            nxt.act  = ACT_MISSED;
          end
        end
      end
      OP_SET_TIME: begin
        nxt.minute = amin;
        nxt.done   = 1'b0;
        nxt.sent   = 4'd0;
        nxt.day    = 16'd0;
      end
      OP_SET_ENABLE: begin
        nxt.enabled = en;
      end
      OP_CONFIRM: begin
        nxt.done = 1'b1;
        nxt.sent = 4'd0;
        nxt.last = 32'd0;
      end
      OP_SNOOZE: begin
        nxt.last = diff;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/dars_table.sv
// Alarm slot table: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dars_table
  import dars_pkg::*;
#(
  parameter int DEPTH = SLOTS_DEFAULT,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/daily_alarm_reminder_scheduler.sv
// Top level: sequencer over the slot table and the shared slot update unit.
// Steps: set time, set enable, confirm and snooze decode, read the slot and write it; append,
//   a rejected item or a tail remove only decode; a remove copies later slots down one by
//   one; a tick updates each used slot, then, if any acted, rereads them to the last one.
// Flow: one item at a time, ready only while idle; one table read port, so one slot at a
//   time; output stalls hold the sequencer. Reset: clears sequencer, used count, output.
`timescale 1ns / 1ps
`default_nettype none

module daily_alarm_reminder_scheduler
  import dars_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  dars_in_if.sink     in_ch,
  dars_out_if.source  out_ch
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  state_t state, state_next;
  cfg_t   cfg;

  logic [CW-1:0] used, used_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] evcnt, evcnt_next;
  logic [CW-1:0] emitted, emitted_next;
  logic [SLOTS-1:0] pend;
  logic [SLOTS-1:0] used_mask;

  mode_t       mode_r;
  logic [2:0]  slot_r;
  logic [10:0] amin_r;
  logic        en_r;
  logic [15:0] day_r;
  logic [10:0] mnow_r;
  logic [31:0] now_r;

  logic [2:0] resp_slot, resp_slot_next;
  action_t    resp_act, resp_act_next;
  status_t    resp_st, resp_st_next;

  logic       out_valid;
  logic [2:0] out_slot;
  action_t    out_act;
  status_t    out_st;
  logic       out_pend;
  logic       out_last;

  logic       out_load;
  logic [2:0] load_slot;
  action_t    load_act;
  status_t    load_st;
  logic       load_last;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data, unit_out, app_e;
  op_t           op;

  logic [7:0]    slot_w, used_w, idx_w;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] ev_total;
  logic [AW-1:0] slot_addr;
  logic          in_acc, slot_ok, time_bad, full, tail_rm, move_end, scan_end;
  logic          ev_hit, out_free, ev2_last, any_pend;

  dars_table #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dars_slot_unit u_unit (
    .op     (op),
    .cur    (rd_data),
    .cfg    (cfg),
    .day    (day_r),
    .minute (mnow_r),
    .now    (now_r),
    .amin   (amin_r),
    .en     (en_r),
    .nxt    (unit_out)
  );

  assign in_ch.ready = (state == S_IDLE) && !rst;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign slot_w    = {5'd0, slot_r};
  assign used_w    = 8'(used);
  assign idx_w     = 8'(idx);
  assign idx_inc   = idx + CW'(1);
  assign slot_addr = slot_w[AW-1:0];
  assign slot_ok   = slot_w < used_w;
  assign time_bad  = amin_r > MINUTE_MAX;
  assign full      = used_w >= 8'(SLOTS);
  assign tail_rm   = (slot_w + 8'd1) >= used_w;
  assign move_end  = (idx_w + 8'd2) >= used_w;
  assign scan_end  = (idx_w + 8'd1) == used_w;
  assign ev_hit    = unit_out.act != ACT_NONE;
  assign ev_total  = evcnt + CW'(ev_hit);
  assign out_free  = !out_valid || out_ch.ready;
  assign ev2_last  = (emitted + CW'(1)) == evcnt;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      used_mask[i] = i < int'(used);
    end
  end

  assign any_pend = |(pend & used_mask);

  always_comb begin
    app_e         = '0;
    app_e.minute  = amin_r;
    app_e.enabled = en_r;
    app_e.act     = ACT_NONE;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        unique case (mode_r)
          MODE_TICK:       state_next = (used == '0) ? S_RESP : S_RD1;
          MODE_APPEND:     state_next = S_RESP;
          MODE_SET_TIME:   state_next = (!slot_ok || time_bad) ? S_RESP : S_ERD;
          MODE_SET_ENABLE,
          MODE_CONFIRM,
          MODE_SNOOZE:     state_next = slot_ok ? S_ERD : S_RESP;
          MODE_REMOVE:     state_next = (!slot_ok || tail_rm) ? S_RESP : S_MRD;
          default:         state_next = S_RESP;
        endcase
      end
      S_RD1: state_next = S_EV1;
      S_EV1: begin
        if (scan_end) begin
          state_next = (ev_total == '0) ? S_RESP : S_RD2;
        end else begin
          state_next = S_RD1;
        end
      end
      S_RD2: state_next = S_EV2;
      S_EV2: begin
        if (rd_data.act == ACT_NONE) begin
          state_next = S_RD2;
        end else if (out_free) begin
          state_next = ev2_last ? S_IDLE : S_RD2;
        end
      end
      S_ERD: state_next = S_EWR;
      S_EWR: state_next = S_RESP;
      S_MRD: state_next = S_MWR;
      S_MWR: state_next = move_end ? S_RESP : S_MRD;
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en          = 1'b0;
    rd_addr        = idx[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = idx[AW-1:0];
    wr_data        = unit_out;
    op             = OP_TICK;
    idx_next       = idx;
    used_next      = used;
    evcnt_next     = evcnt;
    emitted_next   = emitted;
    resp_slot_next = resp_slot;
    resp_act_next  = resp_act;
    resp_st_next   = resp_st;
    out_load       = 1'b0;
    load_slot      = resp_slot;
    load_act       = resp_act;
    load_st        = resp_st;
    load_last      = 1'b1;
    unique case (state)
      S_IDLE: begin
      end
      S_DEC: begin
        resp_slot_next = slot_r;
        resp_act_next  = ACT_ACK;
        resp_st_next   = ST_OK;
        unique case (mode_r)
          MODE_TICK: begin
            idx_next       = '0;
            evcnt_next     = '0;
            resp_slot_next = 3'd0;
            resp_act_next  = ACT_NONE;
          end
          MODE_APPEND: begin
            if (full) begin
              resp_slot_next = 3'd0;
              resp_st_next   = ST_FULL;
            end else begin
              wr_en          = 1'b1;
              wr_addr        = used_w[AW-1:0];
              wr_data        = app_e;
              used_next      = used + CW'(1);
              resp_slot_next = used_w[2:0];
            end
          end
          MODE_SET_TIME: begin
            if (!slot_ok || time_bad) begin
              resp_st_next = ST_RANGE;
            end
          end
          MODE_SET_ENABLE,
          MODE_CONFIRM,
          MODE_SNOOZE: begin
            if (!slot_ok) begin
              resp_st_next = ST_RANGE;
            end
          end
          MODE_REMOVE: begin
            idx_next = slot_w[CW-1:0];
            if (!slot_ok) begin
              resp_st_next = ST_RANGE;
            end else if (tail_rm) begin
              used_next = used - CW'(1);
            end
          end
          default: begin
            resp_slot_next = 3'd0;
            resp_act_next  = ACT_NONE;
          end
        endcase
      end
      S_RD1: begin
        rd_en = 1'b1;
      end
      S_EV1: begin
        wr_en      = 1'b1;
        evcnt_next = ev_total;
        idx_next   = idx_inc;
        if (scan_end) begin
          idx_next     = '0;
          emitted_next = '0;
        end
      end
      S_RD2: begin
        rd_en = 1'b1;
      end
      S_EV2: begin
        load_slot = idx_w[2:0];
        load_act  = rd_data.act;
        load_st   = ST_OK;
        load_last = ev2_last;
        if (rd_data.act == ACT_NONE) begin
          idx_next = idx_inc;
        end else if (out_free) begin
          out_load     = 1'b1;
          emitted_next = emitted + CW'(1);
          idx_next     = idx_inc;
        end
      end
      S_ERD: begin
        rd_en   = 1'b1;
        rd_addr = slot_addr;
      end
      S_EWR: begin
        wr_en   = 1'b1;
        wr_addr = slot_addr;
        unique case (mode_r)
          MODE_SET_TIME:   op = OP_SET_TIME;
          MODE_SET_ENABLE: op = OP_SET_ENABLE;
          MODE_CONFIRM:    op = OP_CONFIRM;
          MODE_SNOOZE:     op = OP_SNOOZE;
          default:         op = OP_TICK;
        endcase
      end
      S_MRD: begin
        rd_en   = 1'b1;
        rd_addr = idx_inc[AW-1:0];
      end
      S_MWR: begin
        wr_en    = 1'b1;
        wr_data  = rd_data;
        idx_next = idx_inc;
        if (move_end) begin
          used_next = used - CW'(1);
        end
      end
      S_RESP: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      used    <= '0;
      idx     <= '0;
      evcnt   <= '0;
      emitted <= '0;
    end else begin
      state   <= state_next;
      used    <= used_next;
      idx     <= idx_next;
      evcnt   <= evcnt_next;
      emitted <= emitted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval <= RESET_INTERVAL;
      cfg.limit    <= RESET_LIMIT;
      cfg.missed   <= RESET_MISSED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERVAL: cfg.interval <= cfg_data;
        CFG_LIMIT:    cfg.limit    <= cfg_data[3:0];
        CFG_MISSED:   cfg.missed   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= mode_t'(in_ch.mode);
      slot_r <= in_ch.slot;
      amin_r <= in_ch.alarm_minute;
      en_r   <= in_ch.enable_flag;
      day_r  <= in_ch.day_number;
      mnow_r <= in_ch.minute_now;
      now_r  <= in_ch.seconds_now;
    end
    resp_slot <= resp_slot_next;
    resp_act  <= resp_act_next;
    resp_st   <= resp_st_next;
    if (wr_en) begin
      pend[wr_addr] <= wr_data.enabled & ~wr_data.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot <= load_slot;
      out_act  <= load_act;
      out_st   <= load_st;
      out_pend <= any_pend;
      out_last <= load_last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.result_slot = out_slot;
  assign out_ch.action      = out_act;
  assign out_ch.status      = out_st;
  assign out_ch.any_pending = out_pend;
  assign out_ch.last_of_run = out_last;

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(SLOTS))
    else $error("used slot count beyond table depth");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EV2 && out_load) |-> (emitted < evcnt))
    else $error("more tick results emitted than counted");

  a_append_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC && mode_r == MODE_APPEND && !full) |=> (used == $past(used) + CW'(1)))
    else $error("append did not grow the table");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && load_last) |=> (state == S_IDLE))
    else $error("final result transfer did not end the item");

endmodule

`default_nettype wire

>>> sim/daily_alarm_reminder_scheduler_tb.sv
// Self-checking testbench for the daily alarm reminder scheduler: random traffic and a table predictor.
`timescale 1ns / 1ps

module daily_alarm_reminder_scheduler_tb;
  import dars_pkg::*;

  localparam int TABLE_SLOTS = 8;
  localparam int END_WAIT = 64;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  slot;
    logic [10:0] alarm_minute;
    logic        enable_flag;
    logic [15:0] day_number;
    logic [10:0] minute_now;
    logic [31:0] seconds_now;
  } item_t;

  typedef struct packed {
    logic [2:0] result_slot;
    action_t    action;
    status_t    status;
    logic       any_pending;
    logic       last_of_run;
  } res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_INTERVAL;
  logic [15:0] cfg_data = 16'd0;

  dars_in_if  in_ch ();
  dars_out_if out_ch ();

  daily_alarm_reminder_scheduler #(.SLOTS(TABLE_SLOTS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  item_t pending_items[$];
  res_t  due_results[$];
  item_t cur_item;
  int    mismatches = 0;
  bit    steady = 1'b0;

  // predicted table and register copies
  int          used_cnt;
  logic [10:0] tbl_minute [TABLE_SLOTS];
  logic        tbl_en     [TABLE_SLOTS];
  logic        tbl_done   [TABLE_SLOTS];
  logic [3:0]  tbl_sent   [TABLE_SLOTS];
  logic [31:0] tbl_last   [TABLE_SLOTS];
  logic [15:0] tbl_day    [TABLE_SLOTS];
  logic [15:0] cfg_interval;
  logic [3:0]  cfg_limit;
  logic [15:0] cfg_missed;

  // stimulus clock
  logic [31:0] gen_sec;
  logic [15:0] gen_day;
  int          gen_min;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic res_t make_result(logic [2:0] s, action_t a, status_t st);
    res_t r;
    r.result_slot = s;
    r.action = a;
    r.status = st;
    r.any_pending = 1'b0;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  task automatic clear_entry(input int i);
    tbl_minute[i] = '0;
    tbl_en[i] = 1'b0;
    tbl_done[i] = 1'b0;
    tbl_sent[i] = '0;
    tbl_last[i] = '0;
    tbl_day[i] = '0;
  endtask

  task automatic predict_reminders(input item_t it);
    res_t        batch[$];
    res_t        r;
    logic [31:0] since;
    logic [2:0]  rs;
    status_t     st;
    logic        pend;
    int          i;
    int          s;
    st = ST_OK;
    rs = it.slot;
    s = int'(it.slot);
    case (it.mode)
      MODE_TICK: begin
        for (i = 0; i < used_cnt; i++) begin
          if (tbl_day[i] != it.day_number) begin
            tbl_done[i] = 1'b0;
            tbl_sent[i] = '0;
            tbl_last[i] = '0;
            tbl_day[i] = it.day_number;
          end
          if (tbl_en[i] && !tbl_done[i] && it.minute_now >= tbl_minute[i]) begin
            since = it.seconds_now - tbl_last[i];
            if (tbl_sent[i] == 4'd0) begin
              tbl_sent[i] = 4'd1;
              tbl_last[i] = it.seconds_now;
              batch.push_back(make_result(3'(i), ACT_FIRST, ST_OK));
            end else if (tbl_sent[i] < cfg_limit && since >= {16'd0, cfg_interval}) begin
              tbl_sent[i] = tbl_sent[i] + 4'd1;
              tbl_last[i] = it.seconds_now;
              batch.push_back(make_result(3'(i), ACT_REPEAT, ST_OK));
            end else if (tbl_sent[i] >= cfg_limit && since >= {16'd0, cfg_missed}) begin
              tbl_done[i] = 1'b1;
              batch.push_back(make_result(3'(i), ACT_MISSED, ST_OK));
            end
          end
        end
        if (batch.size() == 0) batch.push_back(make_result(3'd0, ACT_NONE, ST_OK));
      end
      MODE_APPEND: begin
        if (used_cnt >= TABLE_SLOTS) begin
          st = ST_FULL;
          rs = 3'd0;
        end else begin
          rs = 3'(used_cnt);
          clear_entry(used_cnt);
          tbl_minute[used_cnt] = it.alarm_minute;
          tbl_en[used_cnt] = it.enable_flag;
          used_cnt++;
        end
        batch.push_back(make_result(rs, ACT_ACK, st));
      end
      MODE_SET_TIME, MODE_SET_ENABLE, MODE_REMOVE, MODE_CONFIRM, MODE_SNOOZE: begin
        if (s >= used_cnt) begin
          st = ST_RANGE;
        end else if (it.mode == MODE_SET_TIME) begin
          if (it.alarm_minute > MINUTE_MAX) begin
            st = ST_RANGE;
          end else begin
            tbl_minute[s] = it.alarm_minute;
            tbl_done[s] = 1'b0;
            tbl_sent[s] = '0;
            tbl_day[s] = '0;
          end
        end else if (it.mode == MODE_SET_ENABLE) begin
          tbl_en[s] = it.enable_flag;
        end else if (it.mode == MODE_REMOVE) begin
          for (i = s; i + 1 < used_cnt; i++) begin
            tbl_minute[i] = tbl_minute[i + 1];
            tbl_en[i] = tbl_en[i + 1];
            tbl_done[i] = tbl_done[i + 1];
            tbl_sent[i] = tbl_sent[i + 1];
            tbl_last[i] = tbl_last[i + 1];
            tbl_day[i] = tbl_day[i + 1];
          end
          used_cnt--;
          clear_entry(used_cnt);
        end else if (it.mode == MODE_CONFIRM) begin
          tbl_done[s] = 1'b1;
          tbl_sent[s] = '0;
          tbl_last[s] = '0;
        end else begin
          tbl_last[s] = it.seconds_now - {16'd0, cfg_interval};
        end
        batch.push_back(make_result(rs, ACT_ACK, st));
      end
      default: batch.push_back(make_result(3'd0, ACT_NONE, ST_OK));
    endcase
    pend = 1'b0;
    for (i = 0; i < used_cnt; i++)
      if (tbl_en[i] && !tbl_done[i]) pend = 1'b1;
    for (i = 0; i < batch.size(); i++) begin
      r = batch[i];
      r.any_pending = pend;
      r.last_of_run = (i == batch.size() - 1);
      due_results.push_back(r);
    end
  endtask

  function automatic item_t make_item(logic [2:0] mode, logic [2:0] slot, logic [10:0] amin,
                                      logic en, logic [15:0] day, logic [10:0] mnow,
                                      logic [31:0] snow);
    item_t it;
    it.mode = mode;
    it.slot = slot;
    it.alarm_minute = amin;
    it.enable_flag = en;
    it.day_number = day;
    it.minute_now = mnow;
    it.seconds_now = snow;
    return it;
  endfunction

  function automatic item_t next_stimulus();
    item_t       it;
    int unsigned p;
    int unsigned q;
    logic [31:0] step;
    it.mode = MODE_TICK;
    it.slot = 3'($urandom_range(7));
    it.alarm_minute = 11'($urandom_range(2047));
    it.enable_flag = 1'($urandom_range(1));
    it.day_number = 16'($urandom);
    it.minute_now = 11'($urandom_range(1439));
    it.seconds_now = $urandom;
    p = $urandom_range(99);
    if (p < 55) begin
      q = $urandom_range(99);
      if (q < 30) step = 32'($urandom_range(3));
      else if (q < 75) step = 32'($urandom_range(2 * int'(cfg_interval) + 2));
      else if (q < 95) step = 32'($urandom_range(int'(cfg_missed) + int'(cfg_missed) / 4 + 2));
      else step = $urandom;
      gen_sec = gen_sec + step;
      q = $urandom_range(99);
      if (q < 8) begin
        gen_day = gen_day + 16'd1;
        gen_min = $urandom_range(60);
      end else if (q >= 12) begin
        gen_min = gen_min + $urandom_range(20);
        if (gen_min > 1439) begin
          gen_min = gen_min - 1440;
          gen_day = gen_day + 16'd1;
        end
      end
      it.seconds_now = gen_sec;
      if (q < 8 || q >= 12) begin
        it.day_number = gen_day;
        it.minute_now = 11'(gen_min);
      end
    end else if (p < 66) begin
      it.mode = MODE_APPEND;
      it.enable_flag = ($urandom_range(9) != 0);
      if ($urandom_range(9) == 0) it.alarm_minute = 11'($urandom_range(2047, 1440));
      else if ($urandom_range(1) == 1) it.alarm_minute = 11'($urandom_range(gen_min));
      else it.alarm_minute = 11'($urandom_range(1439));
    end else if (p < 71) begin
      it.mode = MODE_SET_TIME;
      if ($urandom_range(99) < 15) it.alarm_minute = 11'($urandom_range(2047, 1440));
      else it.alarm_minute = 11'($urandom_range(gen_min));
    end else if (p < 77) begin
      it.mode = MODE_SET_ENABLE;
      it.enable_flag = ($urandom_range(3) != 0);
    end else if (p < 83) begin
      it.mode = MODE_REMOVE;
    end else if (p < 90) begin
      it.mode = MODE_CONFIRM;
    end else if (p < 97) begin
      it.mode = MODE_SNOOZE;
      it.seconds_now = gen_sec;
    end else begin
      it.mode = 3'($urandom_range(7));
    end
    return it;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_INTERVAL: cfg_interval = val;
      CFG_LIMIT:    cfg_limit = val[3:0];
      CFG_MISSED:   cfg_missed = val;
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || due_results.size() != 0);
  endtask

  task automatic run_phase(input logic [15:0] interval, input logic [3:0] limit,
                           input logic [15:0] missed, input int count, input bit quiet);
    wait_quiet();
    repeat (END_WAIT) @(posedge clk);
    write_reg(CFG_INTERVAL, interval);
    write_reg(CFG_LIMIT, {12'($urandom), limit});
    write_reg(CFG_MISSED, missed);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    steady = quiet;
    repeat (count) pending_items.push_back(next_stimulus());
  endtask

  // driver: present queued items, predict on each transfer
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_reminders(cur_item);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
          cur_item = pending_items.pop_front();
          in_ch.mode <= cur_item.mode;
          in_ch.slot <= cur_item.slot;
          in_ch.alarm_minute <= cur_item.alarm_minute;
          in_ch.enable_flag <= cur_item.enable_flag;
          in_ch.day_number <= cur_item.day_number;
          in_ch.minute_now <= cur_item.minute_now;
          in_ch.seconds_now <= cur_item.seconds_now;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    res_t exp_res;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result slot=%0d action=%0d status=%0d",
                                    out_ch.result_slot, out_ch.action, out_ch.status));
        end else begin
          exp_res = due_results.pop_front();
          if (out_ch.result_slot !== exp_res.result_slot || out_ch.action !== exp_res.action ||
              out_ch.status !== exp_res.status || out_ch.any_pending !== exp_res.any_pending ||
              out_ch.last_of_run !== exp_res.last_of_run)
            report_mismatch($sformatf(
              "got slot=%0d act=%0d st=%0d pend=%0b last=%0b exp slot=%0d act=%0d st=%0d pend=%0b last=%0b",
              out_ch.result_slot, out_ch.action, out_ch.status, out_ch.any_pending,
              out_ch.last_of_run, exp_res.result_slot, exp_res.action, exp_res.status,
              exp_res.any_pending, exp_res.last_of_run));
        end
      end
      out_ch.ready <= steady || ($urandom_range(99) >= 24);
    end
  end

  initial begin
    int i;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.slot = '0;
    in_ch.alarm_minute = '0;
    in_ch.enable_flag = 1'b0;
    in_ch.day_number = '0;
    in_ch.minute_now = '0;
    in_ch.seconds_now = '0;
    out_ch.ready = 1'b0;
    used_cnt = 0;
    for (i = 0; i < TABLE_SLOTS; i++) clear_entry(i);
    cfg_interval = RESET_INTERVAL;
    cfg_limit = RESET_LIMIT;
    cfg_missed = RESET_MISSED;
    gen_sec = 32'hFFFF_F000;
    gen_day = 16'd6;
    gen_min = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    pending_items.push_back(make_item(MODE_TICK, 3'd0, 11'd0, 1'b0, 16'd5, 11'd0, 32'd10));
    pending_items.push_back(make_item(MODE_SET_TIME, 3'd0, 11'd30, 1'b0, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_UNUSED, 3'd7, 11'h7FF, 1'b1, 16'hFFFF, 11'h7FF,
                                      32'hFFFF_FFFF));
    pending_items.push_back(make_item(MODE_APPEND, 3'd0, 11'd0, 1'b1, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_APPEND, 3'd0, MINUTE_MAX, 1'b1, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_APPEND, 3'd0, 11'd2047, 1'b1, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_APPEND, 3'd0, 11'd600, 1'b0, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_APPEND, 3'd0, 11'd100, 1'b1, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_APPEND, 3'd0, 11'd700, 1'b1, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_APPEND, 3'd0, 11'd1200, 1'b0, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_APPEND, 3'd0, 11'd5, 1'b1, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_APPEND, 3'd0, 11'd9, 1'b1, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_SET_TIME, 3'd3, 11'd2000, 1'b0, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_SET_TIME, 3'd3, MINUTE_MAX, 1'b0, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_SET_ENABLE, 3'd3, 11'd0, 1'b1, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_TICK, 3'd0, 11'd0, 1'b0, 16'd5, MINUTE_MAX,
                                      32'hFFFF_FF00));
    pending_items.push_back(make_item(MODE_TICK, 3'd0, 11'd0, 1'b0, 16'd5, MINUTE_MAX, 32'h30));
    pending_items.push_back(make_item(MODE_SNOOZE, 3'd1, 11'd0, 1'b0, 16'd0, 11'd0, 32'h40));
    pending_items.push_back(make_item(MODE_CONFIRM, 3'd0, 11'd0, 1'b0, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_TICK, 3'd0, 11'd0, 1'b0, 16'd5, MINUTE_MAX, 32'h40));
    pending_items.push_back(make_item(MODE_TICK, 3'd0, 11'd0, 1'b0, 16'd5, MINUTE_MAX,
                                      32'h40 + 32'd1800));
    pending_items.push_back(make_item(MODE_REMOVE, 3'd7, 11'd0, 1'b0, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_REMOVE, 3'd0, 11'd0, 1'b0, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_REMOVE, 3'd7, 11'd0, 1'b0, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_SET_ENABLE, 3'd2, 11'd0, 1'b0, 16'd0, 11'd0, 32'd0));
    pending_items.push_back(make_item(MODE_TICK, 3'd0, 11'd0, 1'b0, 16'd6, 11'd0, 32'h1000));
    pending_items.push_back(make_item(MODE_TICK, 3'd0, 11'd0, 1'b0, 16'd6, MINUTE_MAX, 32'h1001));
    repeat (55) pending_items.push_back(next_stimulus());

    run_phase(16'd1, 4'd1, 16'd1, 55, 1'b0);
    run_phase(16'hFFFF, 4'd15, 16'hFFFF, 55, 1'b0);
    run_phase(16'd0, 4'd15, 16'd5, 55, 1'b0);
    run_phase(16'd20, 4'd0, 16'd40, 55, 1'b0);
    run_phase(16'd60, 4'd5, 16'd200, 60, 1'b1);

    wait_quiet();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("daily_alarm_reminder_scheduler_tb: PASS");
    end else begin
      $display("daily_alarm_reminder_scheduler_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("daily_alarm_reminder_scheduler_tb: FAIL");
    $finish;
  end

endmodule
